FILE: rtl/btpl_pkg.sv
// ----------------------------------------------------------------------------
// Binary trie prefix lookup package
// Shared payload types, command codes and constants of the lookup block.
// ----------------------------------------------------------------------------
package btpl_pkg;

  localparam logic [1:0] CMD_NODE   = 2'd0;
  localparam logic [1:0] CMD_LEAF   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic [1:0] CFG_IPV4_ROOT  = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [1:0] CFG_LEAF_COUNT = 2'd2;

  localparam logic [31:0] NET_NONE_BIT = 32'h8000_0000;
  localparam logic [31:0] MAPPED_TAG   = 32'h0000_FFFF;
  localparam logic [7:0]  V4_BITS      = 8'd32;
  localparam logic [7:0]  V6_BITS      = 8'd128;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [19:0] entry_index;
    logic [19:0] child_zero;
    logic [19:0] child_one;
    logic [31:0] node_net;
    logic [15:0] leaf_country;
    logic [31:0] leaf_asn;
    logic [15:0] leaf_flags;
    logic [1:0]  family;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] country;
    logic [31:0] asn;
    logic [15:0] net_flags;
    logic [18:0] leaf_index;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_NODE,
    JOB_LEAF,
    JOB_WALK,
    JOB_MISS
  } job_kind_e;

  typedef struct packed {
    job_kind_e    kind;
    logic [19:0]  index;
    logic [19:0]  child_zero;
    logic [19:0]  child_one;
    logic [31:0]  net;
    logic [63:0]  leaf;
    logic         v4;
    logic [127:0] bits;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_OUT
  } back_state_e;

endpackage

FILE: rtl/binary_trie_prefix_lookup.sv
// ----------------------------------------------------------------------------
// Binary trie prefix lookup
// Longest-prefix match of IPv4 and IPv6 addresses over a binary trie.
// ----------------------------------------------------------------------------
// Input beats carry node writes, leaf writes and lookups; a beat is taken
// when in_valid_i is high and in_stall_o is low. A two-entry queue decouples
// the classifier from the executing back end, so beats keep being taken
// while a walk runs until the queue is full.
// Writes give no result. A lookup reads one trie node per cycle from the
// single node memory port: a start step issues the root read, each walk
// step visits one node (up to 33 nodes for IPv4, 129 for IPv6), and a final
// step loads the output register.
// Each lookup gives one result beat, held in the output register while
// out_stall_i is high; the back end waits until that register frees.
// Configuration writes on cfg_valid_i are always taken and act at once, so
// the user must issue them only while no beat is in flight; the block does
// not enforce this. Reset clears control and configuration; trie stores are
// undefined until written, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_trie_prefix_lookup #(
  parameter int NODES  = 1048576,
  parameter int LEAVES = 524288
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  btpl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output btpl_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic [19:0] ipv4_root_q;
  logic [20:0] node_count_q;
  logic [19:0] leaf_count_q;
  logic        job_valid, job_pop;
  btpl_pkg::job_t job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_root_q  <= '0;
      node_count_q <= '0;
      leaf_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        btpl_pkg::CFG_IPV4_ROOT:  ipv4_root_q  <= cfg_data_i[19:0];
        btpl_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[20:0];
        btpl_pkg::CFG_LEAF_COUNT: leaf_count_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  btpl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  btpl_back #(
    .NODES  (NODES),
    .LEAVES (LEAVES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_pop_o    (job_pop),
    .ipv4_root_i  (ipv4_root_q),
    .node_count_i (node_count_q),
    .leaf_count_i (leaf_count_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: rtl/btpl_front.sv
// ----------------------------------------------------------------------------
// Binary trie prefix lookup front end
// Accepts input beats, classifies them into jobs and queues them.
// ----------------------------------------------------------------------------
module btpl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  btpl_pkg::in_item_t in_data_i,
  output logic              job_valid_o,
  output btpl_pkg::job_t    job_o,
  input  logic              job_pop_i
);

  btpl_pkg::job_t q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, mapped;
  btpl_pkg::job_t job_new;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_ptr_q];
  assign pop         = job_pop_i && job_valid_o;

  always_comb begin
    mapped = (in_data_i.address_high == 64'd0) &&
             (in_data_i.address_low[63:32] == btpl_pkg::MAPPED_TAG);
    job_new            = '0;
    job_new.index      = in_data_i.entry_index;
    job_new.child_zero = in_data_i.child_zero;
    job_new.child_one  = in_data_i.child_one;
    job_new.net        = in_data_i.node_net;
    job_new.leaf       = {in_data_i.leaf_country, in_data_i.leaf_asn, in_data_i.leaf_flags};
    job_new.kind       = btpl_pkg::JOB_MISS;
    push               = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      unique case (in_data_i.cmd)
        btpl_pkg::CMD_NODE: begin
          push         = 1'b1;
          job_new.kind = btpl_pkg::JOB_NODE;
        end
        btpl_pkg::CMD_LEAF: begin
          push         = 1'b1;
          job_new.kind = btpl_pkg::JOB_LEAF;
        end
        btpl_pkg::CMD_LOOKUP: begin
          push = 1'b1;
          if (in_data_i.family == btpl_pkg::FAM_IPV4 ||
              (in_data_i.family == btpl_pkg::FAM_IPV6 && mapped)) begin
            job_new.kind = btpl_pkg::JOB_WALK;
            job_new.v4   = 1'b1;
            job_new.bits = {in_data_i.address_low[31:0], 96'd0};
          end else if (in_data_i.family == btpl_pkg::FAM_IPV6) begin
            job_new.kind = btpl_pkg::JOB_WALK;
            job_new.bits = {in_data_i.address_high, in_data_i.address_low};
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_new;
    end
  end

endmodule

FILE: rtl/btpl_back.sv
// ----------------------------------------------------------------------------
// Binary trie prefix lookup back end
// Executes store writes and walks the trie one node read per cycle.
// ----------------------------------------------------------------------------
module btpl_back #(
  parameter int NODES  = 1048576,
  parameter int LEAVES = 524288
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  btpl_pkg::job_t     job_i,
  output logic               job_pop_o,
  input  logic [19:0]        ipv4_root_i,
  input  logic [20:0]        node_count_i,
  input  logic [19:0]        leaf_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output btpl_pkg::out_item_t out_data_o
);

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;

  logic [71:0] node_mem [NODES];
  logic [63:0] leaf_mem [LEAVES];
  logic [71:0] node_rd_q;
  logic [63:0] leaf_rd_q;

  btpl_pkg::back_state_e state_q, state_d;
  logic [127:0] bits_q, bits_d;
  logic [7:0]   pos_q, pos_d;
  logic         v4_q, v4_d;
  logic         have_q, have_d;
  logic [31:0]  best_q, best_d;
  logic         found_q, found_d;
  logic         out_valid_q, out_valid_d;
  btpl_pkg::out_item_t out_q, out_d;

  logic          node_we, leaf_we, node_re, leaf_re;
  logic [NW-1:0] node_addr;
  logic [19:0]   start, child;
  logic [31:0]   word, best_n;
  logic          have_n, bits_end, leaf_ok, load_out;

  function automatic logic node_ok(logic [19:0] n, logic [20:0] cnt);
    return ({1'b0, n} < cnt) && (32'(n) < 32'(NODES));
  endfunction

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_out    = (state_q == btpl_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    word     = node_rd_q[31:0];
    have_n   = have_q || !word[31];
    best_n   = word[31] ? best_q : word;
    bits_end = pos_q == (v4_q ? btpl_pkg::V4_BITS : btpl_pkg::V6_BITS);
    child    = bits_q[127] ? node_rd_q[51:32] : node_rd_q[71:52];
    leaf_ok  = have_n && (best_n < {12'd0, leaf_count_i}) && (best_n < 32'(LEAVES));
    start    = job_i.v4 ? ipv4_root_i : 20'd0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btpl_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind == btpl_pkg::JOB_MISS) begin
            state_d = btpl_pkg::ST_OUT;
          end else if (job_i.kind == btpl_pkg::JOB_WALK) begin
            state_d = node_ok(start, node_count_i) ? btpl_pkg::ST_WALK : btpl_pkg::ST_OUT;
          end
        end
      end
      btpl_pkg::ST_WALK: begin
        if (bits_end || child == 20'd0 || !node_ok(child, node_count_i)) begin
          state_d = btpl_pkg::ST_OUT;
        end
      end
      btpl_pkg::ST_OUT: begin
        if (load_out) begin
          state_d = btpl_pkg::ST_IDLE;
        end
      end
      default: state_d = btpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    node_we   = 1'b0;
    leaf_we   = 1'b0;
    node_re   = 1'b0;
    leaf_re   = 1'b0;
    node_addr = NW'(job_i.index);
    bits_d    = bits_q;
    pos_d     = pos_q;
    v4_d      = v4_q;
    have_d    = have_q;
    best_d    = best_q;
    found_d   = found_q;
    unique case (state_q)
      btpl_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          found_d   = 1'b0;
          unique case (job_i.kind)
            btpl_pkg::JOB_NODE: node_we = 32'(job_i.index) < 32'(NODES);
            btpl_pkg::JOB_LEAF: leaf_we = 32'(job_i.index) < 32'(LEAVES);
            btpl_pkg::JOB_WALK: begin
              node_re   = node_ok(start, node_count_i);
              node_addr = NW'(start);
              bits_d    = job_i.bits;
              pos_d     = 8'd0;
              v4_d      = job_i.v4;
              have_d    = 1'b0;
              best_d    = 32'd0;
            end
            default: found_d = 1'b0;
          endcase
        end
      end
      btpl_pkg::ST_WALK: begin
        have_d    = have_n;
        best_d    = best_n;
        node_addr = NW'(child);
        if (bits_end || child == 20'd0) begin
          leaf_re = leaf_ok;
          found_d = leaf_ok;
        end else if (node_ok(child, node_count_i)) begin
          node_re = 1'b1;
          bits_d  = bits_q << 1;
          pos_d   = pos_q + 8'd1;
        end else begin
          found_d = 1'b0;
        end
      end
      default: found_d = found_q;
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (load_out) begin
      out_d = '0;
      if (found_q) begin
        out_d.found      = 1'b1;
        out_d.country    = leaf_rd_q[63:48];
        out_d.asn        = leaf_rd_q[47:16];
        out_d.net_flags  = leaf_rd_q[15:0];
        out_d.leaf_index = best_q[18:0];
      end
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btpl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q  <= bits_d;
    pos_q   <= pos_d;
    v4_q    <= v4_d;
    have_q  <= have_d;
    best_q  <= best_d;
    found_q <= found_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[NW'(job_i.index)] <= {job_i.child_zero, job_i.child_one, job_i.net};
    end
    if (node_re) begin
      node_rd_q <= node_mem[node_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[LW'(job_i.index)] <= job_i.leaf;
    end
    if (leaf_re) begin
      leaf_rd_q <= leaf_mem[LW'(best_n)];
    end
  end

endmodule

FILE: rtl/btpl_checker.sv
// ----------------------------------------------------------------------------
// Binary trie prefix lookup checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module btpl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input btpl_pkg::out_item_t out_data_o,
  input logic                cfg_ready_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      (out_data_o.country == 16'd0 && out_data_o.asn == 32'd0 &&
       out_data_o.net_flags == 16'd0 && out_data_o.leaf_index == 19'd0))
    else $error("not-found result carries leaf data");

  a_reset_quiet : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration channel not ready");

endmodule

bind binary_trie_prefix_lookup btpl_checker u_btpl_checker (.*);
